/* hw/rtl/glyph_flag_coordinate_decoder_unit_defines.svh */
// Assertion macros used by the decoder datapath.
`ifndef GLYPH_FLAG_COORDINATE_DECODER_UNIT_DEFINES_SVH
`define GLYPH_FLAG_COORDINATE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checks that cons holds in the same cycle whenever ante holds.
`define GFCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that cons holds in the cycle after ante holds.
`define GFCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GFCD_ASSERT_IMP(lbl, ante, cons, msg)
`define GFCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/gfcd_pkg.sv */
// Package with the shared widths, flag bit positions, phase codes and interface types.
`timescale 1ns / 1ps

package gfcd_pkg;

	localparam int BYTE_W             = 8;
	localparam int CNT_W              = 6;
	localparam int COORD_W            = 16;
	localparam int IDX_OUT_W          = 5;
	localparam int DEFAULT_MAX_POINTS = 32;

	// Flag byte bit positions.
	localparam int ON_CURVE_BIT = 0;
	localparam int X_SHORT_BIT  = 1;
	localparam int Y_SHORT_BIT  = 2;
	localparam int REPEAT_BIT   = 3;
	localparam int X_SAME_BIT   = 4;
	localparam int Y_SAME_BIT   = 5;

	// Decoding phase codes; bit 1 set means a coordinate phase.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FLAGS = 2'd1;
	localparam logic [1:0] PH_X     = 2'd2;
	localparam logic [1:0] PH_Y     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic fill;
		logic drain;
	} gfcd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic acc_to_fill;
		logic acc_to_drain;
		logic fill_more;
		logic fill_to_coords;
		logic drain_ok;
		logic drain_stop;
	} gfcd_sts_t;

	// One decoded coordinate as presented on the output.
	typedef struct packed {
		logic                      axis;
		logic [IDX_OUT_W-1:0]      point_index;
		logic signed [COORD_W-1:0] coord;
		logic                      on_curve;
		logic                      last_of_run;
		logic                      glyph_done;
	} gfcd_result_t;

endpackage

/* hw/rtl/gfcd_datapath.sv */
// Datapath: flag store, counters, running coordinate, result hold and output registers.
`timescale 1ns / 1ps
`include "glyph_flag_coordinate_decoder_unit_defines.svh"

module gfcd_datapath import gfcd_pkg::*; #(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gfcd_cmd_t          cmd,
	output gfcd_sts_t          sts,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               glyph_start,
	input  logic [CNT_W-1:0]   point_count,
	output logic               res_valid,
	input  logic               res_ready,
	output gfcd_result_t       res
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

	logic [BYTE_W-1:0]  flags_q [MAX_POINTS];
	logic [1:0]         phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   total_q;
	logic               rep_q;
	logic [BYTE_W-1:0]  held_q;
	logic [COORD_W-1:0] run_q;
	logic [BYTE_W:0]    hb_q;
	logic [BYTE_W-1:0]  rep_left_q;
	logic               hold_v_q;
	gfcd_result_t       hold_q;
	logic               out_v_q;
	gfcd_result_t       out_q;

	logic [BYTE_W-1:0]  cur_flag;
	logic               is_y;
	logic               short_bit;
	logic               same_bit;
	logic               cnt_lt_total;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   pc_clamped;
	logic [CNT_W-1:0]   e_cnt;
	logic [CNT_W-1:0]   e_cnt_inc;
	logic [CNT_W-1:0]   e_total;
	logic               e_rep;
	logic               e_flags;
	logic               acc_fill;
	logic               acc_coord;
	logic               acc_flag_end;
	logic               acc_emit;
	logic [COORD_W-1:0] byte_ext;
	logic [COORD_W-1:0] word_delta;
	logic [COORD_W-1:0] run_short;
	logic [COORD_W-1:0] run_word;
	logic [COORD_W-1:0] new_run;
	logic               drain_step;
	logic               drain_emit;
	logic               drain_finish;
	logic               emit;
	logic               move_hold;
	logic               out_free;
	gfcd_result_t       new_res;
	gfcd_result_t       moved_res;

	assign cur_flag     = flags_q[cnt_q[IDX_W-1:0]];
	assign is_y         = (phase_q == PH_Y);
	assign short_bit    = is_y ? cur_flag[Y_SHORT_BIT] : cur_flag[X_SHORT_BIT];
	assign same_bit     = is_y ? cur_flag[Y_SAME_BIT] : cur_flag[X_SAME_BIT];
	assign cnt_lt_total = (cnt_q < total_q);
	assign cnt_inc      = cnt_q + 1'b1;

	always_comb begin
		pc_clamped = point_count;
		if (point_count == '0) begin
			pc_clamped = CNT_W'(1);
		end else if (point_count > MAX_CNT) begin
			pc_clamped = MAX_CNT;
		end
	end

	// A start beat restarts the glyph before its byte is taken as a flag.
	assign e_cnt     = glyph_start ? '0 : cnt_q;
	assign e_cnt_inc = e_cnt + 1'b1;
	assign e_total   = glyph_start ? pc_clamped : total_q;
	assign e_rep     = glyph_start ? 1'b0 : rep_q;
	assign e_flags   = glyph_start || (phase_q == PH_FLAGS);

	assign acc_fill     = e_flags && e_rep;
	assign acc_coord    = !glyph_start && phase_q[1] && cnt_lt_total;
	assign acc_flag_end = e_flags && !e_rep && !data_byte[REPEAT_BIT] && (e_cnt_inc >= e_total);
	assign acc_emit     = cmd.accept && acc_coord && (short_bit || hb_q[BYTE_W]);

	assign byte_ext   = {{(COORD_W-BYTE_W){1'b0}}, data_byte};
	assign word_delta = {hb_q[BYTE_W-1:0], data_byte};
	assign run_short  = same_bit ? (run_q + byte_ext) : (run_q - byte_ext);
	assign run_word   = run_q + word_delta;
	assign new_run    = !cmd.accept ? run_q : (short_bit ? run_short : run_word);

	assign out_free = !out_v_q || res_ready;

	assign sts.acc_to_fill    = acc_fill;
	assign sts.acc_to_drain   = acc_flag_end || acc_coord;
	assign sts.fill_more      = (rep_left_q != '0) && cnt_lt_total;
	assign sts.fill_to_coords = !cnt_lt_total;
	assign sts.drain_ok       = !hold_v_q || out_free;
	assign sts.drain_stop     = !phase_q[1] || (!cnt_lt_total && is_y) ||
		(cnt_lt_total && (short_bit || !same_bit));

	assign drain_step   = cmd.drain && sts.drain_ok;
	assign drain_finish = drain_step && sts.drain_stop;
	assign drain_emit   = drain_step && !sts.drain_stop && cnt_lt_total;
	assign emit         = acc_emit || drain_emit;
	assign move_hold    = hold_v_q && (emit || drain_finish);

	always_comb begin
		new_res             = '0;
		new_res.axis        = is_y;
		new_res.point_index = cnt_q[IDX_OUT_W-1:0];
		new_res.coord       = new_run;
		new_res.on_curve    = cur_flag[ON_CURVE_BIT];
		new_res.last_of_run = 1'b0;
		new_res.glyph_done  = is_y && (cnt_inc == total_q);
	end

	// The result leaving the hold is marked as the last one when the walk stops.
	always_comb begin
		moved_res             = hold_q;
		moved_res.last_of_run = drain_finish;
	end

	// Decoding state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cnt_q      <= '0;
			total_q    <= '0;
			rep_q      <= 1'b0;
			held_q     <= '0;
			run_q      <= '0;
			hb_q       <= '0;
			rep_left_q <= '0;
		end else if (cmd.accept) begin
			if (glyph_start) begin
				total_q <= pc_clamped;
				phase_q <= PH_FLAGS;
				cnt_q   <= '0;
				rep_q   <= 1'b0;
				held_q  <= '0;
				run_q   <= '0;
				hb_q    <= '0;
			end
			if (e_flags) begin
				if (e_rep) begin
					rep_left_q <= data_byte;
					rep_q      <= 1'b0;
				end else begin
					cnt_q <= e_cnt_inc;
					if (data_byte[REPEAT_BIT]) begin
						rep_q  <= 1'b1;
						held_q <= data_byte;
					end
					if (acc_flag_end) begin
						phase_q <= PH_X;
						cnt_q   <= '0;
						run_q   <= '0;
						hb_q    <= '0;
					end
				end
			end else if (acc_coord) begin
				if (short_bit) begin
					run_q <= run_short;
					cnt_q <= cnt_inc;
				end else if (hb_q[BYTE_W]) begin
					run_q <= run_word;
					hb_q  <= '0;
					cnt_q <= cnt_inc;
				end else begin
					hb_q <= {1'b1, data_byte};
				end
			end
		end else if (cmd.fill) begin
			if (sts.fill_more) begin
				cnt_q      <= cnt_inc;
				rep_left_q <= rep_left_q - 1'b1;
			end else if (!cnt_lt_total) begin
				phase_q <= PH_X;
				cnt_q   <= '0;
				run_q   <= '0;
				hb_q    <= '0;
			end
		end else if (drain_step) begin
			if (sts.drain_stop) begin
				if (is_y && !cnt_lt_total) begin
					phase_q <= PH_IDLE;
				end
			end else if (!cnt_lt_total) begin
				phase_q <= PH_Y;
				cnt_q   <= '0;
				run_q   <= '0;
				hb_q    <= '0;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

	// Flag store: at most one entry written per cycle, on an accepted flag byte or a fill step.
	always_ff @(posedge clk) begin
		if (cmd.accept && e_flags && !e_rep) begin
			flags_q[e_cnt[IDX_W-1:0]] <= data_byte;
		end else if (cmd.fill && sts.fill_more) begin
			flags_q[cnt_q[IDX_W-1:0]] <= held_q;
		end
	end

	// The hold stage keeps the newest result until it is known whether another follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit) begin
				hold_v_q <= 1'b1;
			end else if (drain_finish) begin
				hold_v_q <= 1'b0;
			end
			if (move_hold) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hold_q <= new_res;
		end
		if (move_hold) begin
			out_q <= moved_res;
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

	`GFCD_ASSERT_IMP(a_cnt_within_total, phase_q != PH_IDLE, cnt_q <= total_q, "point counter passed the point count")
	`GFCD_ASSERT_IMP(a_total_bounded, 1'b1, total_q <= MAX_CNT, "point count above the store depth")
	`GFCD_ASSERT_IMP(a_accept_hold_empty, cmd.accept, !hold_v_q, "beat accepted with a result still held")
	`GFCD_ASSERT_IMP(a_move_needs_room, move_hold, out_free, "held result moved over an untaken one")
	`GFCD_ASSERT_IMP(a_repeat_in_flags, rep_q, phase_q == PH_FLAGS, "repeat count pending outside the flag phase")

endmodule

/* hw/rtl/gfcd_controller.sv */
// Controller state machine: sequences beat acceptance, flag repeat fill and coordinate drain.
`timescale 1ns / 1ps

module gfcd_controller import gfcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output gfcd_cmd_t cmd,
	input  gfcd_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FILL  = 3'b010,
		S_DRAIN = 3'b100
	} gfcd_state_t;

	gfcd_state_t state_q;
	gfcd_state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					if (sts.acc_to_fill) begin
						state_d = S_FILL;
					end else if (sts.acc_to_drain) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (!sts.fill_more) begin
					state_d = sts.fill_to_coords ? S_DRAIN : S_IDLE;
				end
			end
			S_DRAIN: begin
				cmd.drain = 1'b1;
				if (sts.drain_ok && sts.drain_stop) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/glyph_flag_coordinate_decoder_unit.sv */
// Top level of the simple-glyph flag and coordinate decoder.
`timescale 1ns / 1ps

// The decoder takes the point data of a simple glyph one byte per beat, starting
// at the first flag byte, which carries the start mark and the point count. It
// expands run-length repeated flags into a store of MAX_POINTS entries, then
// decodes the x deltas and the y deltas against those flags and returns one
// beat per point and axis with the absolute coordinate, wrapping at 16 bits.
// Coordinates that take no bytes ("same as previous") come out on their own,
// right after the byte before them or after the final flag; tlast marks the
// last result beat caused by an input beat, and tuser bit 1 marks the last y
// coordinate of the glyph. One beat is worked on at a time. A repeat count
// byte has its held flag written into the store entry by entry, since the
// store has a single write port and is filled one entry a cycle; when it
// completes the flag list, the walk over the coordinates that need no byte
// follows. A coordinate byte, and a flag byte that ends the flag list, are
// followed by the same walk, which releases each further result that needs
// no byte and changes from x to y where the x list ends; these steps walk
// the store one point a cycle while the master side keeps up. Results leave
// through a one-beat hold and an output register, so the next input beat
// is taken while the last result still waits on the master side; a stalled
// master side stops the decoder only when a further result has to be pushed
// out. Bytes that arrive with no glyph in progress are taken and dropped, and
// a start beat abandons any glyph that is still being decoded.
module glyph_flag_coordinate_decoder_unit import gfcd_pkg::*; #(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: input bytes.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [13:8] point_count, [15:14] zero
	input  logic [0:0]  s_tuser,  // [0] glyph_start
	// Master side: decoded coordinates.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [4:0] point_index, [20:5] coord, [21] on_curve, [23:22] zero
	output logic [1:0]  m_tuser,  // [0] axis, [1] glyph_done
	output logic        m_tlast   // last_of_run
);

	gfcd_cmd_t    cmd;
	gfcd_sts_t    sts;
	gfcd_result_t res;

	// The controller only sequences; every piece of decoding state sits in the datapath.
	gfcd_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gfcd_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (s_tdata[7:0]),
		.glyph_start (s_tuser[0]),
		.point_count (s_tdata[13:8]),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	// Pack the result fields onto the master side, lowest field first.
	assign m_tdata = {2'b00, res.on_curve, res.coord, res.point_index};
	assign m_tuser = {res.glyph_done, res.axis};
	assign m_tlast = res.last_of_run;

endmodule
